>>> src/multiframe_id_filter_assert.svh
// Assertion macros for the multiframe ID filter.
`ifndef MULTIFRAME_ID_FILTER_ASSERT_SVH
`define MULTIFRAME_ID_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MFID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mfid_pkg.sv
// Types and constants shared by the multiframe ID filter modules.
package mfid_pkg;

  // Wide enough for the largest slot table (64 slots).
  localparam int unsigned SLOT_IDX_W = 6;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic REG_LOCK_TIME  = 1'b0;
  localparam logic REG_MAX_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_NEW,
    OP_REPEAT
  } op_t;

  // Lookup word walking down the cell row, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    logic                  match_hit;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [7:0]            match_timer;
    logic [7:0]            match_count;
    logic [7:0]            match_tg;
    logic                  zero_hit;
    logic [SLOT_IDX_W-1:0] zero_idx;
    logic [7:0]            zero_timer;
    logic [7:0]            zero_count;
    logic [7:0]            zero_tg;
    logic                  exp_hit;
    logic [SLOT_IDX_W-1:0] exp_idx;
  } search_t;

  // Update broadcast to every cell.
  typedef struct packed {
    op_t                   op;
    logic [SLOT_IDX_W-1:0] idx;
    logic [31:0]           id;
    logic [7:0]            tg;
    logic [7:0]            lock_time;
  } apply_t;

endpackage

>>> src/mfid_cell.sv
// One slot of the filter table plus its stage of the lookup row.
module mfid_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      frame_id,
  input  mfid_pkg::search_t search_prev,
  output mfid_pkg::search_t search,
  input  mfid_pkg::apply_t  apply
);

  logic [31:0] sid;
  logic [7:0]  timer;
  logic [7:0]  count;
  logic [7:0]  tg;

  mfid_pkg::search_t search_next;
  logic              mine;

  assign mine = (apply.idx == mfid_pkg::SLOT_IDX_W'(INDEX));

  // First match, first free ID and first expired timer win; later cells only fill gaps.
  always_comb begin
    search_next = search_prev;
    if (!search_prev.match_hit && sid == frame_id) begin
      search_next.match_hit   = 1'b1;
      search_next.match_idx   = mfid_pkg::SLOT_IDX_W'(INDEX);
      search_next.match_timer = timer;
      search_next.match_count = count;
      search_next.match_tg    = tg;
    end
    if (!search_prev.zero_hit && sid == 32'd0) begin
      search_next.zero_hit   = 1'b1;
      search_next.zero_idx   = mfid_pkg::SLOT_IDX_W'(INDEX);
      search_next.zero_timer = timer;
      search_next.zero_count = count;
      search_next.zero_tg    = tg;
    end
    if (!search_prev.exp_hit && timer == 8'd0) begin
      search_next.exp_hit = 1'b1;
      search_next.exp_idx = mfid_pkg::SLOT_IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search <= '0;
    end else begin
      search <= search_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sid   <= '0;
      timer <= '0;
      count <= '0;
      tg    <= '0;
    end else begin
      case (apply.op)
        mfid_pkg::OP_TICK: begin
          if (timer != 8'd0) begin
            timer <= timer - 8'd1;
          end
        end
        mfid_pkg::OP_NEW: begin
          if (mine) begin
            sid   <= apply.id;
            timer <= apply.lock_time;
            count <= 8'd1;
            tg    <= apply.tg;
          end
        end
        mfid_pkg::OP_REPEAT: begin
          if (mine) begin
            count <= count + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/multiframe_id_filter.sv
// A frame's lookup word walks the slot cell row one cell per cycle, is captured in fin,
// and its result is registered once the output is free; a tick word takes effect at its
// acceptance edge and gives no result. Ticks are taken one per cycle while idle; frames
// are taken one at a time, each only after the last one's result is registered;
// a stalled result holds the next frame back for as long as the stall lasts.
// Reset: synchronous, active high; clears the slot table, sets lock_time 10, max_frames 3.
`include "multiframe_id_filter_assert.svh"

module multiframe_id_filter #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [31:0] sensor_id,
  input  logic [7:0]  telegram_counter,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        multi_frame,
  output logic        no_slot,
  output logic [3:0]  slot_used
);

  localparam logic [3:0] NONE_CODE = 4'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;

  logic [7:0]  lock_time;
  logic [7:0]  max_frames;
  logic [31:0] frame_id;
  logic [7:0]  frame_tg;
  logic [31:0] search_key;

  mfid_pkg::search_t chain [0:SLOTS];
  mfid_pkg::search_t fin;
  mfid_pkg::apply_t  apply;
  logic [SLOTS-1:0]  walk_vec;

  logic                            accept;
  logic                            out_free;
  logic                            sel_hit;
  logic [mfid_pkg::SLOT_IDX_W-1:0] sel_idx;
  logic [7:0]                      sel_timer;
  logic [7:0]                      sel_count;
  logic [7:0]                      sel_tg;
  logic                            tg_valid;
  logic                            is_new;
  logic                            is_repeat;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // The first cell compares in the accept cycle, before frame_id is loaded.
  assign search_key = (state == ST_IDLE) ? sensor_id : frame_id;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept && (command == mfid_pkg::CMD_FRAME);
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    mfid_cell #(
      .INDEX(k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .frame_id   (search_key),
      .search_prev(chain[k]),
      .search     (chain[k+1]),
      .apply      (apply)
    );
    assign walk_vec[k] = chain[k+1].valid;
  end

  // Exact match first, then first free ID, then first expired timer.
  always_comb begin
    sel_hit   = 1'b0;
    sel_idx   = '0;
    sel_timer = '0;
    sel_count = '0;
    sel_tg    = '0;
    if (fin.match_hit) begin
      sel_hit   = 1'b1;
      sel_idx   = fin.match_idx;
      sel_timer = fin.match_timer;
      sel_count = fin.match_count;
      sel_tg    = fin.match_tg;
    end else if (fin.zero_hit) begin
      sel_hit   = 1'b1;
      sel_idx   = fin.zero_idx;
      sel_timer = fin.zero_timer;
      sel_count = fin.zero_count;
      sel_tg    = fin.zero_tg;
    end else if (fin.exp_hit) begin
      sel_hit = 1'b1;
      sel_idx = fin.exp_idx;
    end
    tg_valid  = (frame_tg != 8'd0);
    is_new    = (sel_timer == 8'd0) || (tg_valid && sel_tg != frame_tg);
    is_repeat = !is_new && ((sel_count < max_frames) || (tg_valid && sel_tg == frame_tg));
  end

  always_comb begin
    apply.op        = mfid_pkg::OP_NONE;
    apply.idx       = sel_idx;
    apply.id        = frame_id;
    apply.tg        = frame_tg;
    apply.lock_time = lock_time;
    if (accept && command == mfid_pkg::CMD_TICK) begin
      apply.op = mfid_pkg::OP_TICK;
    end else if (state == ST_FINISH && out_free && sel_hit) begin
      if (is_new) begin
        apply.op = mfid_pkg::OP_NEW;
      end else if (is_repeat) begin
        apply.op = mfid_pkg::OP_REPEAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_time  <= 8'd10;
      max_frames <= 8'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mfid_pkg::REG_LOCK_TIME:  lock_time  <= cfg_data;
        mfid_pkg::REG_MAX_FRAMES: max_frames <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      multi_frame  <= 1'b0;
      no_slot      <= 1'b0;
      slot_used    <= '0;
      frame_id     <= '0;
      frame_tg     <= '0;
      fin          <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && command == mfid_pkg::CMD_FRAME) begin
            frame_id <= sensor_id;
            frame_tg <= telegram_counter;
            state    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (chain[SLOTS].valid) begin
            fin   <= chain[SLOTS];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            multi_frame  <= sel_hit && is_repeat;
            no_slot      <= !sel_hit;
            slot_used    <= sel_hit ? 4'(sel_idx) : NONE_CODE;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MFID_ASSERT_IMP(a_tail_only_in_search, chain[SLOTS].valid, state == ST_SEARCH, "lookup word left the row outside search")
  `MFID_ASSERT_IMP(a_one_word_in_row, 1'b1, $onehot0(walk_vec), "more than one lookup word in the cell row")
  `MFID_ASSERT_NXT(a_frame_enters_row, accept && command == mfid_pkg::CMD_FRAME, walk_vec[0], "accepted frame did not enter the first cell")
  `MFID_ASSERT_IMP(a_result_from_finish, $rose(result_valid), $past(state) == ST_FINISH, "result appeared outside the finish step")
  `MFID_ASSERT_IMP(a_no_slot_single, result_valid && no_slot, !multi_frame && slot_used == NONE_CODE, "no-slot result marked as repeat or with a slot")

endmodule

>>> dv/tb.sv
// Self-checking testbench for the multiframe ID filter: slot table prediction and scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS          = 8;
  localparam int CLK_PERIOD     = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL           = 12;

  typedef struct packed {
    logic       multi;
    logic       none;
    logic [3:0] slot;
  } verdict_t;

  // Slot table mirror; predicts one verdict per frame word.
  class frame_scoreboard;
    logic [31:0] slot_id   [SLOTS];
    logic [7:0]  lock_left [SLOTS];
    logic [7:0]  frames    [SLOTS];
    logic [7:0]  burst_tg  [SLOTS];
    logic [7:0]  lock_ticks;
    logic [7:0]  frame_limit;
    verdict_t    verdicts[$];
    int          errors;
    int          n_frames, n_ticks, n_repeats, n_exhausted, n_noslot, n_results;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_id[s]   = '0;
        lock_left[s] = '0;
        frames[s]    = '0;
        burst_tg[s]  = '0;
      end
      lock_ticks  = 8'd10;
      frame_limit = 8'd3;
      errors      = 0;
      n_frames    = 0;
      n_ticks     = 0;
      n_repeats   = 0;
      n_exhausted = 0;
      n_noslot    = 0;
      n_results   = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] data);
      if (idx == mfid_pkg::REG_LOCK_TIME) lock_ticks = data;
      else frame_limit = data;
    endfunction

    function void note_word(logic cmd, logic [31:0] id, logic [7:0] tg);
      int       hit, zero_at, expired_at, pick;
      verdict_t v;
      hit        = SLOTS;
      zero_at    = SLOTS;
      expired_at = SLOTS;
      v          = '0;
      if (cmd == mfid_pkg::CMD_TICK) begin
        n_ticks++;
        for (int s = 0; s < SLOTS; s++)
          if (lock_left[s] != 0) lock_left[s] = lock_left[s] - 8'd1;
        return;
      end
      n_frames++;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_id[s] == id) begin
          hit = s;
          break;
        end
        if (slot_id[s] == 0 && zero_at == SLOTS) zero_at = s;
        if (lock_left[s] == 0 && expired_at == SLOTS) expired_at = s;
      end
      pick = (hit < SLOTS) ? hit : ((zero_at < SLOTS) ? zero_at : expired_at);
      if (pick < SLOTS) begin
        if (lock_left[pick] == 0 || (tg != 0 && burst_tg[pick] != tg)) begin
          // new burst reopens the slot
          slot_id[pick]   = id;
          lock_left[pick] = lock_ticks;
          frames[pick]    = 8'd1;
          burst_tg[pick]  = tg;
        end else if (frames[pick] < frame_limit || (tg != 0 && burst_tg[pick] == tg)) begin
          frames[pick] = frames[pick] + 8'd1;
          v.multi      = 1'b1;
          n_repeats++;
        end else begin
          n_exhausted++;
        end
      end else begin
        v.none = 1'b1;
        n_noslot++;
      end
      v.slot = 4'(pick);
      verdicts.push_back(v);
    endfunction

    function void check_result(logic multi, logic none, logic [3:0] slot);
      verdict_t v;
      n_results++;
      if (verdicts.size() == 0) begin
        $error("result word with no frame pending");
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (multi !== v.multi) begin
        $error("multi_frame: expected %0d, got %0d", v.multi, multi);
        errors++;
      end
      if (none !== v.none) begin
        $error("no_slot: expected %0d, got %0d", v.none, none);
        errors++;
      end
      if (slot !== v.slot) begin
        $error("slot_used: expected %0d, got %0d", v.slot, slot);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        command = mfid_pkg::CMD_TICK;
  logic [31:0] sensor_id = '0;
  logic [7:0]  telegram_counter = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        multi_frame;
  logic        no_slot;
  logic [3:0]  slot_used;

  frame_scoreboard sb = new();

  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int rx_max      = 0;
  bit rx_stalling = 1'b0;
  int rx_run      = 0;
  int idle_cycles = 0;
  int settings    = 1;

  multiframe_id_filter #(.SLOTS(SLOTS)) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .sensor_id       (sensor_id),
    .telegram_counter(telegram_counter),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .multi_frame     (multi_frame),
    .no_slot         (no_slot),
    .slot_used       (slot_used)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: alternating runs of stall and free cycles, off when rx_max is 0.
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_stalling = !rx_stalling;
      rx_run = rx_stalling ? $urandom_range(1, (rx_max > 0) ? rx_max : 1)
                           : $urandom_range(1, 20);
    end else begin
      rx_run--;
    end
    result_stall <= rx_stalling && (rx_max > 0);
  end

  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        sb.check_result(multi_frame, no_slot, slot_used);
        moved = 1'b1;
      end
      if (item_valid && !item_stall) begin
        sb.note_word(command, sensor_id, telegram_counter);
        moved = 1'b1;
      end
      if (cfg_write) sb.set_reg(cfg_index, cfg_data);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps when gaps_on is set.
  task automatic send_word(input logic cmd, input logic [31:0] id, input logic [7:0] tg);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 15) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    item_valid       <= 1'b1;
    command          <= cmd;
    sensor_id        <= id;
    telegram_counter <= tg;
    do @(posedge clk); while (item_stall);
    burst_left--;
  endtask

  task automatic park_sender();
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic program_reg(input logic idx, input logic [7:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait out the last frame, then the pipeline depth, so the block is idle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] lock, input logic [7:0] maxf, input bit gaps,
                           input int rxm, input int tick_pct, input int count);
    logic [31:0] pool    [POOL];
    logic [7:0]  pool_tg [POOL];
    logic [7:0]  tg;
    int          r, p;
    program_reg(mfid_pkg::REG_LOCK_TIME, lock);
    program_reg(mfid_pkg::REG_MAX_FRAMES, maxf);
    settings++;
    gaps_on = gaps;
    rx_max  = rxm;
    for (int k = 0; k < POOL; k++) begin
      pool[k]    = $urandom;
      pool_tg[k] = 8'($urandom_range(1, 255));
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        send_word(mfid_pkg::CMD_TICK, $urandom, 8'($urandom));
      end else if (r < 88) begin
        // recurring sensors with mostly consistent telegram counters
        p = $urandom_range(0, POOL - 1);
        case ($urandom_range(0, 4))
          0, 1: tg = pool_tg[p];
          2: tg = 8'h00;
          3: begin
            pool_tg[p] = 8'($urandom_range(1, 255));
            tg = pool_tg[p];
          end
          default: tg = 8'($urandom);
        endcase
        send_word(mfid_pkg::CMD_FRAME, pool[p], tg);
      end else if (r < 96) begin
        send_word(mfid_pkg::CMD_FRAME, $urandom, 8'($urandom));
      end else begin
        send_word(mfid_pkg::CMD_FRAME, 32'h0, 8'($urandom_range(0, 3)));
      end
    end
    park_sender();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset register values.
    gaps_on = 1'b1;
    rx_max  = 4;
    repeat (4) send_word(mfid_pkg::CMD_FRAME, 32'hFFFF_FFFF, 8'h00); // new, repeat x2, exhausted
    send_word(mfid_pkg::CMD_FRAME, 32'hFFFF_FFFF, 8'hFF);     // new telegram reopens burst
    send_word(mfid_pkg::CMD_FRAME, 32'h0000_0000, 8'h00);     // ID zero takes an empty slot
    for (int k = 1; k <= 7; k++)                              // fill the remaining slots
      send_word(mfid_pkg::CMD_FRAME, 32'h100 + k, 8'(k));
    repeat (10) send_word(mfid_pkg::CMD_TICK, $urandom, 8'($urandom)); // all locks run out
    send_word(mfid_pkg::CMD_FRAME, 32'h5555_5555, 8'h80);     // expired slot reused
    park_sender();
    drain();

    run_phase(8'd10, 8'd3, 1'b1, 30, 30, 125);
    run_phase(8'd0, 8'd0, 1'b0, 0, 25, 125);
    run_phase(8'd255, 8'd255, 1'b1, 4, 30, 125);
    run_phase(8'd1, 8'd1, 1'b1, 12, 35, 125);
    run_phase(8'($urandom_range(2, 20)), 8'($urandom_range(0, 6)), 1'b1, 30, 40, 125);
    run_phase(8'd6, 8'd2, 1'b0, 8, 35, 125);

    $display("Ran %0d frame words and %0d tick words under %0d register settings",
             sb.n_frames, sb.n_ticks, settings);
    $display("Outcomes: %0d repeats, %0d exhausted bursts, %0d with no free slot",
             sb.n_repeats, sb.n_exhausted, sb.n_noslot);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
